>>> src/sdte_pkg.sv
package sdte_pkg;

  // field widths
  localparam int NUM_W   = 32;
  localparam int CHAR_W  = 6;

  // decimal digits needed for a 32-bit magnitude
  localparam int MAX_DIGITS  = 10;
  localparam int DIGIT_W     = 4;
  localparam int BCD_W       = MAX_DIGITS * DIGIT_W;
  localparam int DIGIT_CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int SHIFT_CNT_W = $clog2(NUM_W);

  // queue between converter and emitter
  localparam int FIFO_DEPTH = 2;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int FILL_W     = $clog2(FIFO_DEPTH + 1);

  // character codes
  localparam logic [CHAR_W-1:0] CH_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CH_MINUS = 6'd45;

  // one converted number waiting to be printed
  typedef struct packed {
    logic             neg;
    logic [BCD_W-1:0] digits;
  } entry_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

>>> src/sdte_if.sv
interface sdte_num_if;
  import sdte_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [NUM_W-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

interface sdte_char_if;
  import sdte_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

>>> src/sdte_conv.sv
module sdte_conv (
  input  logic                  clk,
  input  logic                  rst,
  sdte_num_if.sink              numbers,
  output logic                  push_valid,
  output sdte_pkg::entry_t      push_data,
  input  sdte_pkg::fifo_status_t status
);
  import sdte_pkg::*;

  typedef enum logic [1:0] {
    F_IDLE,
    F_SHIFT,
    F_PUSH
  } state_t;

  state_t                 state;
  logic [SHIFT_CNT_W-1:0] shift_cnt;
  logic [NUM_W-1:0]       mag;
  logic [BCD_W-1:0]       bcd;
  logic                   neg;
  logic [BCD_W-1:0]       bcd_adj;
  logic [NUM_W-1:0]       raw;

  assign raw = numbers.number;

  // add three to every digit of five or more before the shift
  always_comb begin
    for (int d = 0; d < MAX_DIGITS; d++) begin
      if (bcd[d*DIGIT_W +: DIGIT_W] >= 4'd5) begin
        bcd_adj[d*DIGIT_W +: DIGIT_W] = bcd[d*DIGIT_W +: DIGIT_W] + 4'd3;
      end else begin
        bcd_adj[d*DIGIT_W +: DIGIT_W] = bcd[d*DIGIT_W +: DIGIT_W];
      end
    end
  end

  assign numbers.ready    = (state == F_IDLE);
  assign push_valid       = (state == F_PUSH);
  assign push_data.neg    = neg;
  assign push_data.digits = bcd;

  // sign split, then one shift step a cycle, then push once the queue has room
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= F_IDLE;
      shift_cnt <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (numbers.valid) begin
            neg       <= raw[NUM_W-1];
            mag       <= raw[NUM_W-1] ? (NUM_W'(0) - raw) : raw;
            bcd       <= '0;
            shift_cnt <= '0;
            state     <= F_SHIFT;
          end
        end
        F_SHIFT: begin
          bcd       <= {bcd_adj[BCD_W-2:0], mag[NUM_W-1]};
          mag       <= {mag[NUM_W-2:0], 1'b0};
          shift_cnt <= shift_cnt + 1'b1;
          if (shift_cnt == SHIFT_CNT_W'(NUM_W - 1)) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!status.full) begin
            state <= F_IDLE;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

endmodule

>>> src/sdte_fifo.sv
module sdte_fifo (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push_valid,
  input  sdte_pkg::entry_t       push_data,
  input  logic                   pop_ready,
  output sdte_pkg::entry_t       pop_data,
  output sdte_pkg::fifo_status_t status
);
  import sdte_pkg::*;

  entry_t            slots [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;
  logic              do_push;
  logic              do_pop;

  assign status.full  = (fill == FILL_W'(FIFO_DEPTH));
  assign status.empty = (fill == '0);
  assign do_push      = push_valid && !status.full;
  assign do_pop       = pop_ready && !status.empty;
  assign pop_data     = slots[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

>>> src/sdte_emit.sv
module sdte_emit (
  input  logic                   clk,
  input  logic                   rst,
  input  sdte_pkg::entry_t       pop_data,
  input  sdte_pkg::fifo_status_t status,
  output logic                   pop_ready,
  sdte_char_if.source            text
);
  import sdte_pkg::*;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SKIP,
    B_EMIT
  } state_t;

  state_t                 state;
  logic [BCD_W-1:0]       digits;
  logic [DIGIT_CNT_W-1:0] remaining;
  logic                   sign_pending;
  logic [DIGIT_W-1:0]     top_digit;
  logic                   out_free;

  assign top_digit = digits[BCD_W-1 -: DIGIT_W];
  assign out_free  = !text.valid || text.ready;
  assign pop_ready = (state == B_IDLE);

  // load, drop leading zeros, then emit one character per word
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      text.valid <= 1'b0;
    end else begin
      // the emit step refills the output itself whenever it is free
      if (text.ready && state != B_EMIT) begin
        text.valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (!status.empty) begin
            digits       <= pop_data.digits;
            sign_pending <= pop_data.neg;
            remaining    <= DIGIT_CNT_W'(MAX_DIGITS);
            state        <= B_SKIP;
          end
        end
        B_SKIP: begin
          // keep at least one digit so zero prints as a single '0'
          if (top_digit == '0 && remaining > DIGIT_CNT_W'(1)) begin
            digits    <= {digits[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            remaining <= remaining - 1'b1;
          end else begin
            state <= B_EMIT;
          end
        end
        B_EMIT: begin
          if (out_free) begin
            text.valid <= 1'b1;
            if (sign_pending) begin
              text.character <= CH_MINUS;
              text.last      <= 1'b0;
              sign_pending   <= 1'b0;
            end else begin
              text.character <= CH_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, top_digit};
              text.last      <= (remaining == DIGIT_CNT_W'(1));
              digits         <= {digits[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
              remaining      <= remaining - 1'b1;
              if (remaining == DIGIT_CNT_W'(1)) begin
                state <= B_IDLE;
              end
            end
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

>>> src/signed_decimal_text_emitter_unit.sv
// channel   modport  payload               word
// numbers   sink     number (32, signed)   one value to print
// text      source   character (6), last   one ascii character, last marks end
//
// the converter takes a number, then runs 32 double-dabble shift steps and
// writes the queue, and takes no new number until that entry is queued
// the emitter runs beside it: it loads an entry, drops leading zeros,
// then emits one character a cycle while text is ready (up to eleven)
// a two-entry queue lets either side stall without holding the other
// synchronous reset empties the queue and clears both control machines
module signed_decimal_text_emitter_unit (
  input  logic        clk,
  input  logic        rst,
  sdte_num_if.sink    numbers,
  sdte_char_if.source text
);
  import sdte_pkg::*;

  logic         push_valid;
  entry_t       push_data;
  entry_t       pop_data;
  logic         pop_ready;
  fifo_status_t status;

  // front: sign split and binary to bcd
  sdte_conv u_conv (
    .clk        (clk),
    .rst        (rst),
    .numbers    (numbers),
    .push_valid (push_valid),
    .push_data  (push_data),
    .status     (status)
  );

  // queue of converted numbers
  sdte_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .status     (status)
  );

  // back: character emission
  sdte_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .pop_data  (pop_data),
    .status    (status),
    .pop_ready (pop_ready),
    .text      (text)
  );

`ifndef SYNTH
  // a minus sign never ends the text
  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    (text.valid && text.character == CH_MINUS) |-> !text.last)
    else $error("minus sign flagged as last character");

  // converter is busy right after taking a number
  a_conv_busy: assert property (@(posedge clk) disable iff (rst)
    (numbers.valid && numbers.ready) |=> !numbers.ready)
    else $error("converter ready straight after accepting a number");

  // queue cannot be both full and empty
  a_fifo_status: assert property (@(posedge clk) disable iff (rst)
    !(status.full && status.empty))
    else $error("queue status inconsistent");

  // digits stay within '0' to '9'
  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    (text.valid && text.character != CH_MINUS) |->
      (text.character >= CH_ZERO && text.character <= CH_ZERO + 6'd9))
    else $error("character outside digit range");
`endif

endmodule

>>> tb/tb_signed_decimal_text_emitter_unit.sv
`timescale 1ns / 100ps

module tb_signed_decimal_text_emitter_unit;
  import sdte_pkg::*;

  localparam int N_RANDOM    = 480;
  localparam int N_CALM      = 80;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_WAIT  = 60;
  localparam int MAX_REPORTS = 40;

  // one expected character of printed text
  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } text_char_t;

  // holds the text still owed for every accepted number
  class text_scoreboard;
    text_char_t owed_text[$];
    int         errors;

    function new();
      errors = 0;
    endfunction

    function int pending();
      return owed_text.size();
    endfunction

    // decimal text of an accepted number, most significant digit first
    function void note_number(logic signed [NUM_W-1:0] num);
      logic [NUM_W-1:0]   mag;
      logic [DIGIT_W-1:0] digs [MAX_DIGITS];
      int                 nd;
      mag = num[NUM_W-1] ? (32'd0 - num) : num;
      nd  = 0;
      if (mag == 0) begin
        owed_text.push_back('{CH_ZERO, 1'b1});
        return;
      end
      while (mag != 0 && nd < MAX_DIGITS) begin
        digs[nd] = DIGIT_W'(mag % 10);
        mag      = mag / 10;
        nd++;
      end
      if (num[NUM_W-1])
        owed_text.push_back('{CH_MINUS, 1'b0});
      for (int i = nd - 1; i >= 0; i--)
        owed_text.push_back('{CH_ZERO + CHAR_W'(digs[i]), i == 0});
    endfunction

    // compare one accepted character with the oldest one owed
    function void check_char(logic [CHAR_W-1:0] ch, logic fin);
      text_char_t want;
      if (owed_text.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected word: expected none, actual char %0d last %0b",
                   $time, ch, fin);
        return;
      end
      want = owed_text.pop_front();
      if (want.character !== ch || want.last !== fin) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: text mismatch: expected char %0d last %0b, actual char %0d last %0b",
                   $time, want.character, want.last, ch, fin);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   idle_on;
  int   quiet_cycles = 0;

  int unsigned pow10 [MAX_DIGITS] = '{1, 10, 100, 1000, 10000, 100000, 1000000,
                                      10000000, 100000000, 1000000000};

  text_scoreboard sb;

  sdte_num_if  num_if ();
  sdte_char_if txt_if ();

  signed_decimal_text_emitter_unit dut (
    .clk     (clk),
    .rst     (rst),
    .numbers (num_if.sink),
    .text    (txt_if.source)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // offer one number, held until the block takes it
  task automatic send_number(input logic signed [NUM_W-1:0] num);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap           = $urandom_range(1, 8);
      num_if.valid  = 1'b0;
      num_if.number = $urandom;
      repeat (gap) @(negedge clk);
    end
    num_if.valid  = 1'b1;
    num_if.number = num;
    do @(posedge clk); while (!num_if.ready);
    sb.note_number(num);
    @(negedge clk);
  endtask

  // hold the sender off until all owed text has come out
  task automatic wait_for_text();
    num_if.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  function automatic bit case_neg();
    return $urandom_range(0, 1) == 1;
  endfunction

  // random value, biased to short numbers and decade edges
  function automatic logic signed [NUM_W-1:0] pick_number();
    logic signed [NUM_W-1:0] num;
    int                      d;
    case ($urandom_range(0, 3))
      0: num = $urandom;
      1: num = $urandom >> $urandom_range(0, 31);
      2: begin
        d   = $urandom_range(1, MAX_DIGITS - 1);
        num = pow10[d] - 1 + $urandom_range(0, 2);
      end
      default: num = $urandom_range(0, 99);
    endcase
    if (case_neg()) num = -num;
    return num;
  endfunction

  // text side: ready in random bursts of stall
  initial begin
    int stall_left;
    stall_left   = 0;
    txt_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        txt_if.ready = 1'b0;
        stall_left--;
      end else begin
        txt_if.ready = 1'b1;
        if (idle_on && $urandom_range(0, 5) == 0)
          stall_left = $urandom_range(1, 8);
      end
    end
  end

  // check text and watch for a stuck block
  always @(posedge clk) begin
    if (!rst) begin
      if (txt_if.valid && txt_if.ready)
        sb.check_char(txt_if.character, txt_if.last);
      if ((txt_if.valid && txt_if.ready) || (num_if.valid && num_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    logic signed [NUM_W-1:0] directed [$];
    sb            = new();
    idle_on       = 1'b1;
    rst           = 1'b1;
    num_if.valid  = 1'b0;
    num_if.number = '0;
    directed = '{32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10, 32'sd99,
                 32'sd100, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000001,
                 32'sd1000000000, 32'sd999999999, -32'sd999999999,
                 -32'sd1000000000, 32'sd123456789, -32'sd5, 32'sh55555555,
                 32'shAAAAAAAA, 32'sd4000, -32'sd2147483647};
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // directed edges
    foreach (directed[i]) send_number(directed[i]);
    wait_for_text();

    // random part, calm at the end
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM - N_CALM) idle_on = 1'b0;
      if (i % 120 == 60) wait_for_text();
      send_number(pick_number());
    end
    num_if.valid = 1'b0;

    // drain
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (sb.errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
